FILE: src/swm_pkg.sv
// Shared types and constants for the sliding window mode/sum unit.
// No dependencies; imported by the top module and the scan ALU, used by the testbench.
package swm_pkg;

    localparam int VALUE_W = 32;
    localparam int WS_W    = 7;
    localparam int SUM_W   = 64;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Per-entry outcome of one scan step.
    typedef struct packed {
        logic hit;     // live entry holds the incoming value
        logic free;    // entry is empty after the update
        logic better;  // entry beats the best so far
    } t_scan_flags;

endpackage

FILE: src/sliding_window_mode_sum_unit.sv
// Sliding window mode with saturating running sum of modes.
// Each item passes S_RING_RD, an entry-by-entry table S_SCAN and S_FINISH; items that
// start a sequence or follow reset or a register write first clear the table (S_CLEAR).
// A new item is accepted only in S_IDLE; S_FINISH waits while an untaken result is held.
// Reset: synchronous active low; window size 1, table swept on the first item.
// Depends on swm_pkg, swm_ram, swm_scan_alu.
module sliding_window_mode_sum_unit #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [swm_pkg::WS_W-1:0]           i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [swm_pkg::VALUE_W-1:0] i_sample_value,
    input  logic                               i_sequence_start,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [swm_pkg::VALUE_W-1:0] o_window_mode,
    output logic [swm_pkg::WS_W-1:0]           o_mode_count,
    output logic signed [swm_pkg::SUM_W-1:0]   o_mode_sum
);
    import swm_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int TE_W  = VALUE_W + CNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_MAX - 1);

    typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_RING_RD, S_SCAN, S_FINISH} t_state;

    t_state                     r_state;
    logic [WS_W-1:0]            r_ws;
    logic                       r_clr_pend;
    logic [IDX_W-1:0]           r_pos;
    logic [IDX_W-1:0]           r_pos_eff;
    logic [CNT_W-1:0]           r_fill;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [VALUE_W-1:0]  r_v;
    logic [IDX_W-1:0]           r_idx;
    logic                       r_evict;
    logic                       r_found;
    logic                       r_has_free;
    logic [IDX_W-1:0]           r_free;
    logic signed [VALUE_W-1:0]  r_best_v;
    logic [CNT_W-1:0]           r_best_c;
    logic                       r_out_valid;
    logic signed [VALUE_W-1:0]  r_mode;
    logic [WS_W-1:0]            r_mcount;
    logic signed [SUM_W-1:0]    r_osum;

    logic [CNT_W-1:0]           w_eff;
    logic [IDX_W-1:0]           pos_eff;
    logic [CNT_W-1:0]           pos_inc;
    logic [IDX_W-1:0]           n_pos;
    logic [CNT_W-1:0]           n_fill;
    logic                       emit;
    logic                       fin_go;
    logic                       ins_better;
    logic signed [VALUE_W-1:0]  fin_v;
    logic [CNT_W-1:0]           fin_c;
    logic signed [SUM_W-1:0]    mode_ext;
    logic signed [SUM_W-1:0]    sum_add;
    logic signed [SUM_W-1:0]    n_sum;

    logic                       tbl_we;
    logic [IDX_W-1:0]           tbl_waddr;
    logic [TE_W-1:0]            tbl_wdata;
    logic [IDX_W-1:0]           tbl_raddr;
    logic [TE_W-1:0]            tbl_rdata;
    logic signed [VALUE_W-1:0]  ent_val;
    logic [CNT_W-1:0]           ent_cnt;
    logic [CNT_W-1:0]           upd_cnt;
    t_scan_flags                flags;
    logic signed [VALUE_W-1:0]  ring_q;

    // Effective window: zero reads as one, large values clamp.
    always_comb begin
        if (r_ws == '0) begin
            w_eff = CNT_W'(1);
        end else if (int'(r_ws) > WINDOW_MAX) begin
            w_eff = CNT_W'(WINDOW_MAX);
        end else begin
            w_eff = CNT_W'(r_ws);
        end
    end

    assign pos_eff = (CNT_W'(r_pos) >= w_eff) ? '0 : r_pos;
    assign pos_inc = CNT_W'(r_pos_eff) + CNT_W'(1);
    assign n_pos   = (pos_inc >= w_eff) ? '0 : IDX_W'(pos_inc);
    assign n_fill  = (r_fill < w_eff) ? r_fill + CNT_W'(1) : r_fill;
    assign emit    = (n_fill >= w_eff);
    assign fin_go  = !r_out_valid || i_out_ready;

    // New value not in the table enters with count one.
    assign ins_better = !r_found &&
                        ((r_best_c == '0) ||
                         ((r_best_c == CNT_W'(1)) && (r_v < r_best_v)));
    assign fin_v = ins_better ? r_v : r_best_v;
    assign fin_c = ins_better ? CNT_W'(1) : r_best_c;

    assign mode_ext = {{(SUM_W-VALUE_W){fin_v[VALUE_W-1]}}, fin_v};
    assign sum_add  = r_sum + mode_ext;
    always_comb begin
        if ((r_sum[SUM_W-1] == mode_ext[SUM_W-1]) && (sum_add[SUM_W-1] != r_sum[SUM_W-1])) begin
            n_sum = r_sum[SUM_W-1] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = sum_add;
        end
    end

    assign ent_val = tbl_rdata[TE_W-1:CNT_W];
    assign ent_cnt = tbl_rdata[CNT_W-1:0];

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = r_idx;
        tbl_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                tbl_we = 1'b1;
            end
            S_SCAN: begin
                tbl_we    = 1'b1;
                tbl_wdata = {ent_val, upd_cnt};
            end
            S_FINISH: begin
                tbl_we    = fin_go && !r_found;
                tbl_waddr = r_free;
                tbl_wdata = {r_v, CNT_W'(1)};
            end
            default: begin
                tbl_we = 1'b0;
            end
        endcase
    end

    assign tbl_raddr = (r_state == S_SCAN) ? r_idx + IDX_W'(1) : '0;

    swm_ram #(
        .WIDTH (TE_W),
        .DEPTH (WINDOW_MAX)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_re    (1'b1),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    swm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_FINISH) && fin_go),
        .i_waddr (r_pos_eff),
        .i_wdata (r_v),
        .i_re    (r_state == S_RING_RD),
        .i_raddr (pos_eff),
        .o_rdata (ring_q)
    );

    swm_scan_alu #(
        .CNT_W (CNT_W)
    ) u_alu (
        .i_ent_value  (ent_val),
        .i_ent_count  (ent_cnt),
        .i_old_value  (ring_q),
        .i_new_value  (r_v),
        .i_evict      (r_evict),
        .i_best_value (r_best_v),
        .i_best_count (r_best_c),
        .o_count      (upd_cnt),
        .o_flags      (flags)
    );

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_window_mode = r_mode;
    assign o_mode_count  = r_mcount;
    assign o_mode_sum    = r_osum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ws        <= WS_W'(1);
            r_clr_pend  <= 1'b1;
            r_pos       <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !((r_state == S_FINISH) && emit)) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_ws       <= i_cfg_wdata;
                r_clr_pend <= 1'b1;
                r_pos      <= '0;
                r_fill     <= '0;
                r_sum      <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_v   <= i_sample_value;
                        r_idx <= '0;
                        if (i_sequence_start || r_clr_pend) begin
                            r_clr_pend <= 1'b0;
                            r_pos      <= '0;
                            r_fill     <= '0;
                            r_sum      <= '0;
                            r_state    <= S_CLEAR;
                        end else begin
                            r_state <= S_RING_RD;
                        end
                    end
                end
                S_CLEAR: begin
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_RING_RD;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_RING_RD: begin
                    r_evict    <= (r_fill >= w_eff);
                    r_pos_eff  <= pos_eff;
                    r_idx      <= '0;
                    r_found    <= 1'b0;
                    r_has_free <= 1'b0;
                    r_free     <= '0;
                    r_best_c   <= '0;
                    r_best_v   <= '0;
                    r_state    <= S_SCAN;
                end
                S_SCAN: begin
                    if (flags.hit) begin
                        r_found <= 1'b1;
                    end
                    if (flags.free && !r_has_free) begin
                        r_free     <= r_idx;
                        r_has_free <= 1'b1;
                    end
                    if (flags.better) begin
                        r_best_c <= upd_cnt;
                        r_best_v <= ent_val;
                    end
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_FINISH: begin
                    if (fin_go) begin
                        r_pos  <= n_pos;
                        r_fill <= n_fill;
                        if (emit) begin
                            r_sum       <= n_sum;
                            r_out_valid <= 1'b1;
                            r_mode      <= fin_v;
                            r_mcount    <= WS_W'(fin_c);
                            r_osum      <= n_sum;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/swm_ram.sv
// Simple dual-port RAM: one write port, one registered read port with enable.
// No package dependencies; used for the sample ring and the value/count table.
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/swm_scan_alu.sv
// Scan step unit: updates one table entry's count for eviction/insertion
// and compares it against the running best. Depends on swm_pkg.
module swm_scan_alu #(
    parameter int CNT_W = 7
) (
    input  logic signed [swm_pkg::VALUE_W-1:0] i_ent_value,
    input  logic        [CNT_W-1:0]            i_ent_count,
    input  logic signed [swm_pkg::VALUE_W-1:0] i_old_value,
    input  logic signed [swm_pkg::VALUE_W-1:0] i_new_value,
    input  logic                               i_evict,
    input  logic signed [swm_pkg::VALUE_W-1:0] i_best_value,
    input  logic        [CNT_W-1:0]            i_best_count,
    output logic        [CNT_W-1:0]            o_count,
    output swm_pkg::t_scan_flags               o_flags
);
    import swm_pkg::*;

    logic live;
    logic dec;
    logic hit;

    assign live = (i_ent_count != '0);
    assign hit  = live && (i_ent_value == i_new_value);
    assign dec  = live && i_evict && (i_ent_value == i_old_value);

    always_comb begin
        o_count = i_ent_count + CNT_W'(hit) - CNT_W'(dec);
        o_flags.hit    = hit;
        o_flags.free   = (o_count == '0);
        o_flags.better = (o_count != '0) &&
                         ((o_count > i_best_count) ||
                          ((o_count == i_best_count) && (i_ent_value < i_best_value)));
    end

endmodule

FILE: bench/sliding_window_mode_sum_unit_tb.sv
// Testbench for sliding_window_mode_sum_unit: valid/ready stimulus with random idling,
// an in-bench window/mode predictor and an in-order result scoreboard.
// Depends on swm_pkg and the sliding_window_mode_sum_unit RTL.
`timescale 1ns / 100ps

module sliding_window_mode_sum_unit_tb;

    localparam int WIN_MAX   = 64;
    localparam int SETTLE    = 2 * WIN_MAX + 70;
    localparam int SHOW_MAX  = 10;
    localparam int IDLE_PCT  = 37;

    localparam logic signed [swm_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [swm_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic signed [swm_pkg::VALUE_W-1:0] value;
        logic                               start;
    } t_sample_item;

    typedef struct {
        logic signed [swm_pkg::VALUE_W-1:0] mode;
        logic [swm_pkg::WS_W-1:0]           count;
        logic signed [swm_pkg::SUM_W-1:0]   sum;
    } t_mode_result;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_we = 1'b0;
    logic [swm_pkg::WS_W-1:0]           i_cfg_wdata = '0;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic signed [swm_pkg::VALUE_W-1:0] i_sample_value = '0;
    logic                               i_sequence_start = 1'b0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic signed [swm_pkg::VALUE_W-1:0] o_window_mode;
    logic [swm_pkg::WS_W-1:0]           o_mode_count;
    logic signed [swm_pkg::SUM_W-1:0]   o_mode_sum;

    t_sample_item sample_q[$];
    t_mode_result mode_q[$];
    int           mismatches = 0;
    int           idle_in = IDLE_PCT;
    int           idle_out = IDLE_PCT;

    // predictor state
    logic [swm_pkg::WS_W-1:0]           win_reg = 7'd1;
    logic signed [swm_pkg::VALUE_W-1:0] ring_mem [WIN_MAX];
    logic signed [swm_pkg::VALUE_W-1:0] tbl_val [WIN_MAX];
    int                                 tbl_cnt [WIN_MAX];
    int                                 ring_pos = 0;
    int                                 fill = 0;
    logic signed [swm_pkg::SUM_W-1:0]   run_sum = '0;

    sliding_window_mode_sum_unit #(
        .WINDOW_MAX (WIN_MAX)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sample_value   (i_sample_value),
        .i_sequence_start (i_sequence_start),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_window_mode    (o_window_mode),
        .o_mode_count     (o_mode_count),
        .o_mode_sum       (o_mode_sum)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_window();
        for (int e = 0; e < WIN_MAX; e++) begin
            tbl_cnt[e] = 0;
        end
        ring_pos = 0;
        fill = 0;
        run_sum = '0;
    endfunction

    function automatic int find_value(input logic signed [swm_pkg::VALUE_W-1:0] v);
        for (int e = 0; e < WIN_MAX; e++) begin
            if (tbl_cnt[e] != 0 && tbl_val[e] == v) begin
                return e;
            end
        end
        return -1;
    endfunction

    // Advances the window by one sample; returns 1 when the window is full.
    function automatic bit step_window(input logic signed [swm_pkg::VALUE_W-1:0] v,
                                       input logic start, output t_mode_result r);
        int                                 w;
        int                                 pos;
        int                                 hit;
        int                                 slot;
        int                                 best_cnt;
        logic signed [swm_pkg::VALUE_W-1:0] best_val;
        logic [swm_pkg::SUM_W:0]            wide;
        w = (win_reg == 0) ? 1 : ((win_reg > WIN_MAX) ? WIN_MAX : int'(win_reg));
        if (start) begin
            clear_window();
        end
        pos = (ring_pos >= w) ? 0 : ring_pos;
        if (fill >= w) begin
            hit = find_value(ring_mem[pos]);
            if (hit >= 0) begin
                tbl_cnt[hit]--;
            end
        end
        hit = find_value(v);
        if (hit >= 0) begin
            tbl_cnt[hit]++;
        end else begin
            slot = -1;
            for (int e = 0; e < WIN_MAX; e++) begin
                if (tbl_cnt[e] == 0 && slot < 0) begin
                    slot = e;
                end
            end
            if (slot >= 0) begin
                tbl_val[slot] = v;
                tbl_cnt[slot] = 1;
            end
        end
        ring_mem[pos] = v;
        pos++;
        ring_pos = (pos >= w) ? 0 : pos;
        if (fill < w) begin
            fill++;
        end
        if (fill < w) begin
            return 1'b0;
        end
        best_cnt = 0;
        best_val = '0;
        for (int e = 0; e < WIN_MAX; e++) begin
            if (tbl_cnt[e] != 0 &&
                (tbl_cnt[e] > best_cnt || (tbl_cnt[e] == best_cnt && tbl_val[e] < best_val))) begin
                best_cnt = tbl_cnt[e];
                best_val = tbl_val[e];
            end
        end
        wide = {run_sum[swm_pkg::SUM_W-1], run_sum} +
               {{(swm_pkg::SUM_W - swm_pkg::VALUE_W + 1){best_val[swm_pkg::VALUE_W-1]}},
                best_val};
        if (wide[swm_pkg::SUM_W] != wide[swm_pkg::SUM_W-1]) begin
            run_sum = wide[swm_pkg::SUM_W] ? swm_pkg::SUM_MIN : swm_pkg::SUM_MAX;
        end else begin
            run_sum = wide[swm_pkg::SUM_W-1:0];
        end
        r.mode  = best_val;
        r.count = 7'(best_cnt);
        r.sum   = run_sum;
        return 1'b1;
    endfunction

    function automatic logic signed [swm_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: begin
                return VAL_MIN;
            end
            1: begin
                return VAL_MAX;
            end
            2: begin
                return -32'sd1;
            end
            3, 4, 5: begin
                return $urandom_range(6) - 3;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic queue_item(input logic start, input logic signed [swm_pkg::VALUE_W-1:0] v);
        t_sample_item it;
        it.start = start;
        it.value = v;
        sample_q.push_back(it);
    endtask

    // Sequences drawn from small value pools, with stray values and early restarts.
    task automatic queue_sequences(input int n);
        logic signed [swm_pkg::VALUE_W-1:0] pool [8];
        int                                 pool_n;
        t_sample_item                       it;
        pool_n = 1;
        for (int i = 0; i < n; i++) begin
            if (i == 0 || $urandom_range(99) < 3) begin
                pool_n = $urandom_range(1, 8);
                for (int k = 0; k < pool_n; k++) begin
                    pool[k] = pick_value();
                end
                it.start = (i != 0) || ($urandom_range(1) == 1);
            end else begin
                it.start = 1'b0;
            end
            it.value = ($urandom_range(99) < 12) ? $urandom : pool[$urandom_range(pool_n - 1)];
            sample_q.push_back(it);
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (sample_q.size() != 0 || i_in_valid || mode_q.size() != 0);
    endtask

    // Items with no result may still be in flight: allow the full latency first.
    task automatic write_window(input logic [swm_pkg::WS_W-1:0] ws);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ws;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        win_reg = ws;
        clear_window();
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive_samples
        t_sample_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= idle_in) begin
                nxt = sample_q.pop_front();
                i_in_valid       <= 1'b1;
                i_sample_value   <= nxt.value;
                i_sequence_start <= nxt.start;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_mode_result want;
        t_mode_result fresh;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= idle_out);
            if (o_out_valid && i_out_ready) begin
                if (mode_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX) begin
                        $display("unexpected result: mode %0d count %0d sum %0d",
                                 o_window_mode, o_mode_count, o_mode_sum);
                    end
                end else begin
                    want = mode_q.pop_front();
                    if (o_window_mode !== want.mode || o_mode_count !== want.count ||
                        o_mode_sum !== want.sum) begin
                        mismatches++;
                        if (mismatches <= SHOW_MAX) begin
                            $display("mismatch: mode %0d/%0d count %0d/%0d sum %0d/%0d",
                                     want.mode, o_window_mode, want.count, o_mode_count,
                                     want.sum, o_mode_sum);
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (step_window(i_sample_value, i_sequence_start, fresh)) begin
                    mode_q.push_back(fresh);
                end
            end
        end
    end

    initial begin : run_phases
        logic [swm_pkg::WS_W-1:0] ws_list [11];
        int                       n;
        ws_list = '{7'd3, 7'd127, 7'd1, 7'd8, 7'd64, 7'd5, 7'd2, 7'd0, 7'd16, 7'd6, 7'd0};
        ws_list[10] = 7'($urandom_range(127));
        clear_window();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // window of one after reset: extremes and a restart
        queue_item(1'b1, VAL_MIN);
        queue_item(1'b0, VAL_MIN);
        queue_item(1'b0, VAL_MAX);
        queue_item(1'b0, 32'sd0);
        queue_item(1'b1, -32'sd1);
        queue_item(1'b0, 32'sd1);
        // zero size acts as one
        write_window(7'd0);
        queue_item(1'b0, 32'sh5555_5555);
        queue_item(1'b0, 32'shAAAA_AAAA);
        // ties go to the smaller value; restart refills before any result
        write_window(7'd2);
        queue_item(1'b1, 32'sd10);
        queue_item(1'b0, -32'sd10);
        queue_item(1'b0, 32'sd10);
        queue_item(1'b0, 32'sd10);
        queue_item(1'b1, 32'sd7);
        queue_item(1'b0, VAL_MIN);

        foreach (ws_list[p]) begin
            write_window(ws_list[p]);
            n = (ws_list[p] >= 16) ? 80 : 55;
            if (p == 2) begin
                idle_in  = 0;
                idle_out = 0;
            end else begin
                idle_in  = IDLE_PCT;
                idle_out = IDLE_PCT;
            end
            if (p == 3) begin
                queue_sequences(n / 2);
                wait_drained();
                queue_sequences(n - n / 2);
            end else begin
                queue_sequences(n);
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && mode_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule
